// ----- rtl/fwa_pkg.sv -----
// fwa_pkg: shared types and constants for the flow window adjust block
// used by fwa_cfg, fwa_calc and flow_window_adjust_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fwa_pkg;

  localparam int unsigned WinW = 31;
  localparam int unsigned CntW = 32;

  localparam logic [WinW-1:0] MaxWindowReset = {WinW{1'b1}};

  // 34-bit signed limits of the 32-bit counters
  localparam logic signed [33:0] I32Max = 34'sd2147483647;
  localparam logic signed [33:0] I32Min = -34'sd2147483648;

  typedef struct packed {
    logic [WinW-1:0]        local_window;
    logic signed [CntW-1:0] recv_window;
    logic [WinW-1:0]        owed_reduction;
    logic signed [CntW-1:0] delta;
  } fwa_in_t;

  typedef struct packed {
    logic                   flow_error;
    logic [WinW-1:0]        new_local_window;
    logic signed [CntW-1:0] new_recv_window;
    logic [WinW-1:0]        new_owed_reduction;
    logic signed [CntW-1:0] new_delta;
    logic                   send_update;
  } fwa_res_t;

endpackage

`default_nettype wire

// ----- rtl/fwa_cfg.sv -----
// fwa_cfg: max_window configuration register with its write handshake
// depends on fwa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fwa_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [fwa_pkg::WinW-1:0]  cfg_max_window_i,
  output logic [fwa_pkg::WinW-1:0]       max_window_o
);
  import fwa_pkg::*;

  logic [WinW-1:0] max_window_q, max_window_d;

  // register is always free to take a write
  assign cfg_ready_o = 1'b1;

  always_comb begin
    max_window_d = max_window_q;
    if (cfg_valid_i) begin
      max_window_d = cfg_max_window_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_window_q <= MaxWindowReset;
    end else begin
      max_window_q <= max_window_d;
    end
  end

  assign max_window_o = max_window_q;

endmodule

`default_nettype wire

// ----- rtl/fwa_calc.sv -----
// fwa_calc: combinational window adjustment for one item
// depends on fwa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fwa_calc (
  input  wire fwa_pkg::fwa_in_t          item_i,
  input  wire logic [fwa_pkg::WinW-1:0]  max_window_i,
  output fwa_pkg::fwa_res_t              res_o
);
  import fwa_pkg::*;

  logic signed [33:0] lw, rw, rr, d, mw;
  logic signed [33:0] base, excess, paid, lw_sum;
  logic signed [33:0] lw_f, rw_f, rr_f, d_f;
  logic               d_pos, err;

  // everything widened to 34-bit signed
  assign lw = $signed({3'b000, item_i.local_window});
  assign rw = $signed({{2{item_i.recv_window[31]}}, item_i.recv_window});
  assign rr = $signed({3'b000, item_i.owed_reduction});
  assign d  = $signed({{2{item_i.delta[31]}}, item_i.delta});
  assign mw = $signed({3'b000, max_window_i});

  assign d_pos  = !item_i.delta[31] && (item_i.delta != '0);
  assign base   = rw[33] ? 34'sd0 : rw;
  assign excess = d - base;
  assign paid   = (rr < excess) ? rr : excess;
  assign lw_sum = lw + excess;

  always_comb begin
    err  = 1'b0;
    lw_f = lw;
    rw_f = rw;
    rr_f = rr;
    d_f  = d;
    if (d_pos) begin
      if (excess <= 34'sd0) begin
        // credit fully absorbed by received bytes
        rw_f = rw - d;
      end else if (lw_sum > mw) begin
        err = 1'b1;
      end else begin
        lw_f = lw_sum;
        rr_f = rr - paid;
        rw_f = rw[33] ? (rw + paid) : paid;
        d_f  = d - paid;
      end
    end else begin
      // silent shrink with range checks
      if ((lw + d < 34'sd0) || (rw + d < I32Min) || (rr - d > I32Max)) begin
        err = 1'b1;
      end else begin
        lw_f = lw + d;
        rw_f = rw + d;
        rr_f = rr - d;
        d_f  = 34'sd0;
      end
    end
  end

  always_comb begin
    res_o.flow_error         = err;
    res_o.new_local_window   = lw_f[WinW-1:0];
    res_o.new_recv_window    = rw_f[CntW-1:0];
    res_o.new_owed_reduction = rr_f[WinW-1:0];
    res_o.new_delta          = d_f[CntW-1:0];
    res_o.send_update        = (rw_f >= $signed({4'b0000, lw_f[WinW-1:1]}));
  end

endmodule

`default_nettype wire

// ----- rtl/flow_window_adjust_top.sv -----
// flow_window_adjust_top: top level of the flow window adjust block
// depends on fwa_pkg, fwa_cfg and fwa_calc
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel (in_valid_i / in_ready_o) carries one item: local window,
//   received count, pending reduction and signed delta
// - output channel (out_valid_o / out_ready_i) returns one result item per
//   input item, in order: error flag, adjusted fields and send_update
// - config channel (cfg_valid_i / cfg_ready_o) writes max_window; it is
//   always ready and must only be written while the block is idle
// - path: an accepted item goes through the input register, then the
//   result register
// - throughput: one item per cycle while the receiver takes results, set
//   by the single combinational adjust stage between the two registers
// - receiver stall: the result register holds; the input register keeps
//   taking items until it too is full, then in_ready_o drops
// - reset: both stages empty, max_window returns to 2147483647

module flow_window_adjust_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [fwa_pkg::WinW-1:0]          cfg_max_window_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [fwa_pkg::WinW-1:0]          local_window_i,
  input  wire logic signed [fwa_pkg::CntW-1:0]   recv_window_i,
  input  wire logic [fwa_pkg::WinW-1:0]          owed_reduction_i,
  input  wire logic signed [fwa_pkg::CntW-1:0]   delta_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   flow_error_o,
  output logic [fwa_pkg::WinW-1:0]               new_local_window_o,
  output logic signed [fwa_pkg::CntW-1:0]        new_recv_window_o,
  output logic [fwa_pkg::WinW-1:0]               new_owed_reduction_o,
  output logic signed [fwa_pkg::CntW-1:0]        new_delta_o,
  output logic                                   send_update_o
);
  import fwa_pkg::*;

  logic [WinW-1:0] max_window;

  fwa_in_t  in_q, in_d;
  fwa_res_t res_q, res_d, calc_res;
  logic     s1_valid_q, s1_valid_d;
  logic     s2_valid_q, s2_valid_d;
  logic     s2_take, s1_take;

  fwa_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_max_window_i (cfg_max_window_i),
    .max_window_o     (max_window)
  );

  fwa_calc u_calc (
    .item_i       (in_q),
    .max_window_i (max_window),
    .res_o        (calc_res)
  );

  // result register is free when empty or being drained this cycle
  assign s2_take    = !s2_valid_q || out_ready_i;
  // input register is free when empty or moving on into the result register
  assign in_ready_o = !s1_valid_q || s2_take;
  assign s1_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_d       = in_q;
    s1_valid_d = s1_valid_q;
    res_d      = res_q;
    s2_valid_d = s2_valid_q;
    if (s2_take) begin
      s2_valid_d = s1_valid_q;
      res_d      = calc_res;
    end
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    if (s1_take) begin
      in_d.local_window   = local_window_i;
      in_d.recv_window    = recv_window_i;
      in_d.owed_reduction = owed_reduction_i;
      in_d.delta          = delta_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
  end

  assign out_valid_o          = s2_valid_q;
  assign flow_error_o         = res_q.flow_error;
  assign new_local_window_o   = res_q.new_local_window;
  assign new_recv_window_o    = res_q.new_recv_window;
  assign new_owed_reduction_o = res_q.new_owed_reduction;
  assign new_delta_o          = res_q.new_delta;
  assign send_update_o        = res_q.send_update;

endmodule

`default_nettype wire

// ----- rtl/fwa_checker.sv -----
// fwa_checker: port-level assertions for flow_window_adjust_top
// bound to the top level; uses no package
`timescale 1ns / 1ps
`default_nettype none

module fwa_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [30:0]        cfg_max_window_i,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [30:0]        local_window_i,
  input wire logic signed [31:0] recv_window_i,
  input wire logic [30:0]        owed_reduction_i,
  input wire logic signed [31:0] delta_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               flow_error_o,
  input wire logic [30:0]        new_local_window_o,
  input wire logic signed [31:0] new_recv_window_o,
  input wire logic [30:0]        new_owed_reduction_o,
  input wire logic signed [31:0] new_delta_o,
  input wire logic               send_update_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_local_window_o)
      && $stable(new_recv_window_o) && $stable(new_delta_o)
      && $stable(flow_error_o))
    else $error("stalled result changed");

  // send_update follows the delivered window fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> send_update_o ==
      ($signed({new_recv_window_o[31], new_recv_window_o})
        >= $signed({2'b00, new_local_window_o[30:1]})))
    else $error("send_update inconsistent with result");

  // an accepted adjustment never leaves a negative delta
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !flow_error_o |-> !new_delta_o[31])
    else $error("negative delta after accepted adjustment");

  // an empty output side never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind flow_window_adjust_top fwa_checker u_fwa_checker (.*);

`default_nettype wire
